FILE: rtl/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// Types and constants shared by the frame tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pft_pkg;

    localparam int OFS_W  = 19;
    localparam int FS_W   = 17;
    localparam int RAK_W  = 2;
    localparam int RAO_W  = 16;
    localparam int TDATA_W = 56;

    localparam logic [OFS_W-1:0] OFS_LIMIT = 19'h7FFFF;
    localparam int               OFS_WORDS = 32'h7FFFF / 4;

    // instruction words and opcode patterns
    localparam logic [31:0] INSN_MFLR   = 32'h7c0802a6;
    localparam logic [31:0] INSN_MTLR   = 32'h7c0803a6;
    localparam logic [31:0] INSN_BLR    = 32'h4e800020;
    localparam logic [15:0] OP_STW_R0   = 16'h9001;
    localparam logic [15:0] OP_LWZ_R0   = 16'h8001;
    localparam logic [15:0] OP_STWU_R1  = 16'h9421;
    localparam logic [15:0] OP_ADDI_R1  = 16'h3821;
    localparam logic [31:0] XO_MASK     = 32'hFC1F07FE;
    localparam logic [31:0] XO_STWUX_R1 = 32'h7C01016E;
    localparam logic [31:0] XO_MR_R1    = 32'h7C010378;

    localparam logic signed [FS_W-1:0] FS_UNKNOWN = -17'sd1;

    localparam logic SP_IN_REG = 1'b0;
    localparam logic SP_FRAME  = 1'b1;

    localparam logic [RAK_W-1:0] RA_IN_LR    = 2'd0;
    localparam logic [RAK_W-1:0] RA_IN_R0    = 2'd1;
    localparam logic [RAK_W-1:0] RA_ON_STACK = 2'd2;

    localparam logic REC_START = 1'b0;
    localparam logic REC_END   = 1'b1;

    typedef struct packed {
        logic                     sp_kind;
        logic signed [FS_W-1:0]   frame_size;
        logic [RAK_W-1:0]         ra_kind;
        logic signed [RAO_W-1:0]  ra_offset;
    } t_interval;

    localparam t_interval IV_RESET = '{
        sp_kind: SP_IN_REG, frame_size: '0, ra_kind: RA_IN_LR, ra_offset: '0};

    typedef struct packed {
        t_interval n_cur;
        logic      fired;
        logic      ra_saved;    // return address store fired
    } t_dec;

    typedef struct packed {
        logic              open;
        logic              rule;
        logic              fin;
        logic [OFS_W-1:0]  ofs;
        t_interval         iv;
    } t_group;

endpackage

`default_nettype wire

FILE: rtl/prologue_epilogue_frame_tracker.sv
// Path: the records of a word pass from the pending-record register to the
//   output register and then out on the master side, one per transaction.
// Throughput: one word per cycle while each word gives at most one record
//   without stalls; output register sends one record per cycle and sets pace.
// Reset: synchronous, active low; clears the interval state, the word
//   counter and both handshake stages.
// ----------------------------------------------------------------------------
// prologue_epilogue_frame_tracker
// Follows stack frame and return address location through a function body
// and emits interval records.
// ----------------------------------------------------------------------------
`default_nettype none

module prologue_epilogue_frame_tracker
    import pft_pkg::*;
#(
    parameter int MAX_WORDS     = 65536,
    parameter int POINTER_BYTES = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // tdata: insn_word
    input  wire logic [31:0]        i_s_axis_tdata,
    // tlast: final_word
    input  wire logic               i_s_axis_tlast,
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    // tdata: byte_offset, sp_kind, frame_size, ra_kind, ra_offset, zero pad
    output logic [TDATA_W-1:0]      o_m_axis_tdata,
    // tuser: record_type
    output logic                    o_m_axis_tuser,
    // tlast: last_of_run
    output logic                    o_m_axis_tlast
);

    localparam int                CNT_W   = $clog2(MAX_WORDS + 1);
    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_WORDS);

    t_interval          r_cur;
    t_interval          r_canon;
    logic               r_canon_taken;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_opened;

    t_dec               dec;
    t_group             grp;
    logic               accept;
    logic [CNT_W-1:0]   nxt;
    logic [31:0]        nxt32;
    logic [OFS_W-1:0]   ofs;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign nxt    = (r_cnt < MAX_CNT) ? CNT_W'(r_cnt + 1'b1) : MAX_CNT;
    assign nxt32  = 32'(nxt);
    assign ofs    = (nxt32 <= 32'(OFS_WORDS)) ? OFS_W'({nxt32[16:0], 2'b00}) : OFS_LIMIT;

    pft_decode #(
        .POINTER_BYTES(POINTER_BYTES)
    ) u_decode (
        .i_insn  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_cur   (r_cur),
        .i_canon (r_canon),
        .o_dec   (dec)
    );

    always_comb begin
        grp.open = !r_opened;
        grp.rule = dec.fired;
        grp.fin  = i_s_axis_tlast;
        grp.ofs  = ofs;
        grp.iv   = dec.n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur         <= IV_RESET;
            r_canon       <= IV_RESET;
            r_canon_taken <= 1'b0;
            r_cnt         <= '0;
            r_opened      <= 1'b0;
        end else if (accept) begin
            if (i_s_axis_tlast) begin
                // function done: back to the reset state
                r_cur         <= IV_RESET;
                r_canon       <= IV_RESET;
                r_canon_taken <= 1'b0;
                r_cnt         <= '0;
                r_opened      <= 1'b0;
            end else begin
                r_cur    <= dec.n_cur;
                r_cnt    <= nxt;
                r_opened <= 1'b1;
                if (dec.ra_saved && !r_canon_taken) begin
                    r_canon       <= dec.n_cur;
                    r_canon_taken <= 1'b1;
                end
            end
        end
    end

    pft_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept && (grp.open || grp.rule || grp.fin)),
        .i_group         (grp),
        .o_ready         (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/pft_decode.sv
// ----------------------------------------------------------------------------
// pft_decode
// Matches one instruction word against the prologue/epilogue rules and
// gives the next interval.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_decode
    import pft_pkg::*;
#(
    parameter int POINTER_BYTES = 8
) (
    input  wire logic [31:0] i_insn,
    input  wire logic        i_last,
    input  wire t_interval   i_cur,
    input  wire t_interval   i_canon,
    output t_dec             o_dec
);

    logic signed [RAO_W-1:0] disp;
    logic signed [17:0]      disp18;
    logic signed [FS_W-1:0]  spd;
    logic signed [17:0]      spd18;
    logic                    ra_slot;

    assign disp    = $signed(i_insn[15:0]);
    assign disp18  = 18'(disp);
    assign spd     = (i_cur.sp_kind == SP_FRAME) ? i_cur.frame_size : '0;
    assign spd18   = 18'(spd);
    assign ra_slot = (spd18 + 18'(POINTER_BYTES)) == disp18;

    always_comb begin
        o_dec.n_cur    = i_cur;
        o_dec.fired    = 1'b0;
        o_dec.ra_saved = 1'b0;
        priority if (i_insn == INSN_MFLR) begin
            o_dec.n_cur.ra_kind   = RA_IN_R0;
            o_dec.n_cur.ra_offset = '0;
            o_dec.fired           = 1'b1;
        end else if (i_insn == INSN_MTLR) begin
            o_dec.n_cur.ra_kind   = RA_IN_LR;
            o_dec.n_cur.ra_offset = '0;
            o_dec.fired           = 1'b1;
        end else if (i_insn[31:16] == OP_STW_R0) begin
            if (ra_slot) begin
                o_dec.n_cur.ra_kind   = RA_ON_STACK;
                o_dec.n_cur.ra_offset = disp;
                o_dec.fired           = 1'b1;
                o_dec.ra_saved        = 1'b1;
            end
        end else if (i_insn[31:16] == OP_LWZ_R0) begin
            if (ra_slot) begin
                o_dec.n_cur.ra_kind   = RA_IN_R0;
                o_dec.n_cur.ra_offset = '0;
                o_dec.fired           = 1'b1;
            end
        end else if (i_insn[31:16] == OP_STWU_R1) begin
            o_dec.n_cur.sp_kind    = SP_FRAME;
            o_dec.n_cur.frame_size = 17'sd0 - FS_W'(disp);
            o_dec.fired            = 1'b1;
        end else if ((i_insn & XO_MASK) == XO_STWUX_R1) begin
            o_dec.n_cur.sp_kind    = SP_FRAME;
            o_dec.n_cur.frame_size = FS_UNKNOWN;
            o_dec.fired            = 1'b1;
        end else if (i_insn[31:16] == OP_ADDI_R1 && disp18 == spd18) begin
            o_dec.n_cur.sp_kind    = SP_IN_REG;
            o_dec.n_cur.frame_size = '0;
            o_dec.fired            = 1'b1;
        end else if ((i_insn & XO_MASK) == XO_MR_R1 &&
                     i_insn[25:21] == i_insn[15:11]) begin
            // mr r1,rx only undoes a frame of known positive size
            if (!spd[FS_W-1] && (spd != '0)) begin
                o_dec.n_cur.sp_kind    = SP_IN_REG;
                o_dec.n_cur.frame_size = '0;
                o_dec.fired            = 1'b1;
            end
        end else if (i_insn == INSN_BLR && !i_last) begin
            // interior return: fall back to the canonical interval
            if (i_cur != i_canon) begin
                o_dec.n_cur = i_canon;
                o_dec.fired = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pft_emit.sv
// ----------------------------------------------------------------------------
// pft_emit
// Holds the records of one word and sends them out one per transaction
// through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_emit
    import pft_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire t_group             i_group,
    output logic                    o_ready,
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    // tdata: byte_offset, sp_kind, frame_size, ra_kind, ra_offset, zero pad
    output logic [TDATA_W-1:0]      o_m_axis_tdata,
    // tuser: record_type
    output logic                    o_m_axis_tuser,
    output logic                    o_m_axis_tlast
);

    // pending records: [0] opening, [1] rule, [2] end
    logic [2:0]        r_pend;
    logic [OFS_W-1:0]  r_ofs;
    t_interval         r_iv;
    logic              r_o_valid;
    logic [TDATA_W-1:0] r_o_data;
    logic              r_o_user;
    logic              r_o_last;

    logic [2:0]        sel;
    logic [2:0]        rem;
    logic              o_free;
    logic [OFS_W-1:0]  n_ofs;
    t_interval         n_iv;
    logic              n_type;

    assign o_free = !r_o_valid || i_m_axis_tready;
    assign sel    = r_pend & (~r_pend + 3'd1);
    assign rem    = r_pend & ~sel;
    assign o_ready = (r_pend == '0) || (o_free && rem == '0);

    always_comb begin
        n_ofs  = r_ofs;
        n_iv   = r_iv;
        n_type = REC_START;
        if (sel[0]) begin
            n_ofs = '0;
            n_iv  = IV_RESET;
        end else if (sel[2]) begin
            n_type = REC_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_free) begin
                r_o_valid <= r_pend != '0;
                r_pend    <= rem;
            end
            if (i_load) begin
                r_pend <= {i_group.fin, i_group.rule, i_group.open};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_o_data <= {1'b0, n_iv.ra_offset, n_iv.ra_kind, n_iv.frame_size,
                         n_iv.sp_kind, n_ofs};
            r_o_user <= n_type;
            r_o_last <= rem == '0;
        end
        if (i_load) begin
            r_ofs <= i_group.ofs;
            r_iv  <= i_group.iv;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;
    assign o_m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire

FILE: rtl/pft_checker.sv
// ----------------------------------------------------------------------------
// pft_checker
// Port-level checks on the frame tracker's record stream.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_stream_checks
    import pft_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_m_axis_tvalid,
    input wire logic               i_m_axis_tready,
    input wire logic [TDATA_W-1:0] o_m_axis_tdata,
    input wire logic               o_m_axis_tuser,
    input wire logic               o_m_axis_tlast
);

    // stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output changed under stall");

    // an end record closes the run of its word
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == REC_END |-> o_m_axis_tlast)
        else $error("end record not last of run");

    // only the opening record sits at offset zero, and it carries reset interval
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[18:0] == '0 |->
            o_m_axis_tuser == REC_START && o_m_axis_tdata[TDATA_W-1:19] == '0)
        else $error("bad record at offset zero");

    // register SP means no frame size
    a_sp_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[19] == SP_IN_REG |->
            o_m_axis_tdata[36:20] == '0)
        else $error("frame size with SP in register");

    // offset only for a return address on the stack
    a_ra_ofs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[38:37] != RA_ON_STACK |->
            o_m_axis_tdata[54:39] == '0)
        else $error("return address offset without stack slot");

endmodule

bind prologue_epilogue_frame_tracker pft_stream_checks u_pft_checker (.*);

`default_nettype wire

FILE: tb/pft_checker.sv
// ----------------------------------------------------------------------------
// pft_checker
// Watches both stream channels of the frame tracker. Each accepted
// instruction word is run through a local model of the prologue/epilogue
// rules. The interval records that the word should produce are queued, and
// every record on the master side is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_checker
    import pft_pkg::*;
#(
    parameter int MAX_WORDS     = 65536,
    parameter int POINTER_BYTES = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    input  wire logic               i_s_tready,
    input  wire logic [31:0]        i_s_tdata,
    input  wire logic               i_s_tlast,
    input  wire logic               i_m_tvalid,
    input  wire logic               i_m_tready,
    input  wire logic [TDATA_W-1:0] i_m_tdata,
    input  wire logic               i_m_tuser,
    input  wire logic               i_m_tlast,
    output int                      o_mismatch_count,
    output int                      o_records_due
);

    // master tdata layout, lowest bit first
    localparam int SPK_LSB = OFS_W;
    localparam int FS_LSB  = SPK_LSB + 1;
    localparam int RAK_LSB = FS_LSB + FS_W;
    localparam int RAO_LSB = RAK_LSB + RAK_W;

    typedef struct packed {
        logic             rec_type;
        logic [OFS_W-1:0] ofs;
        t_interval        iv;
        logic             run_end;
    } frame_rec_t;

    t_interval  cur_iv;
    t_interval  canon_iv;
    logic       canon_taken;
    logic       opened;
    int         word_cnt;
    int         mismatch_count = 0;
    frame_rec_t records_due[$];

    function automatic void clear_tracker();
        cur_iv      = IV_RESET;
        canon_iv    = IV_RESET;
        canon_taken = 1'b0;
        opened      = 1'b0;
        word_cnt    = 0;
    endfunction

    // Apply one instruction word to the tracked frame state and queue the
    // records it gives.
    task automatic track_insn(input logic [31:0] w, input logic fin);
        frame_rec_t       recs[$];
        int               d;
        int               spd;
        int               nxt;
        logic [OFS_W-1:0] ofs;
        logic             fired;
        fired = 1'b0;
        if (!opened) begin
            recs.push_back('{rec_type: REC_START, ofs: '0, iv: cur_iv, run_end: 1'b0});
            opened = 1'b1;
        end
        nxt = (word_cnt < MAX_WORDS) ? word_cnt + 1 : MAX_WORDS;
        ofs = (nxt <= OFS_WORDS) ? OFS_W'(nxt * 4) : OFS_LIMIT;
        d   = int'($signed(w[15:0]));
        spd = cur_iv.sp_kind ? int'($signed(cur_iv.frame_size)) : 0;

        if (w == INSN_MFLR) begin
            cur_iv.ra_kind   = RA_IN_R0;
            cur_iv.ra_offset = '0;
            fired = 1'b1;
        end else if (w == INSN_MTLR) begin
            cur_iv.ra_kind   = RA_IN_LR;
            cur_iv.ra_offset = '0;
            fired = 1'b1;
        end else if (w[31:16] == OP_STW_R0) begin
            if (spd + POINTER_BYTES == d) begin
                cur_iv.ra_kind   = RA_ON_STACK;
                cur_iv.ra_offset = w[15:0];
                fired = 1'b1;
                if (!canon_taken) begin
                    canon_taken = 1'b1;
                    canon_iv    = cur_iv;
                end
            end
        end else if (w[31:16] == OP_LWZ_R0) begin
            if (spd + POINTER_BYTES == d) begin
                cur_iv.ra_kind   = RA_IN_R0;
                cur_iv.ra_offset = '0;
                fired = 1'b1;
            end
        end else if (w[31:16] == OP_STWU_R1) begin
            cur_iv.sp_kind    = SP_FRAME;
            cur_iv.frame_size = FS_W'(-d);
            fired = 1'b1;
        end else if ((w & XO_MASK) == XO_STWUX_R1) begin
            cur_iv.sp_kind    = SP_FRAME;
            cur_iv.frame_size = FS_UNKNOWN;
            fired = 1'b1;
        end else if (w[31:16] == OP_ADDI_R1 && d == spd) begin
            cur_iv.sp_kind    = SP_IN_REG;
            cur_iv.frame_size = '0;
            fired = 1'b1;
        end else if ((w & XO_MASK) == XO_MR_R1 && w[25:21] == w[15:11]) begin
            if (spd > 0) begin
                cur_iv.sp_kind    = SP_IN_REG;
                cur_iv.frame_size = '0;
                fired = 1'b1;
            end
        end else if (w == INSN_BLR && !fin) begin
            // interior return: fall back to the canonical interval
            if (cur_iv != canon_iv) begin
                cur_iv = canon_iv;
                fired  = 1'b1;
            end
        end

        if (fired)
            recs.push_back('{rec_type: REC_START, ofs: ofs, iv: cur_iv, run_end: 1'b0});
        if (fin) begin
            recs.push_back('{rec_type: REC_END, ofs: ofs, iv: cur_iv, run_end: 1'b0});
            clear_tracker();
        end else begin
            word_cnt = nxt;
        end
        if (recs.size() > 0)
            recs[recs.size()-1].run_end = 1'b1;
        foreach (recs[i])
            records_due.push_back(recs[i]);
    endtask

    function automatic int field_err(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        frame_rec_t want;
        if (!i_rst_n) begin
            clear_tracker();
            records_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                track_insn(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (records_due.size() == 0) begin
                    $display("%0t: record with none expected: expected none, actual tdata %h tuser %b tlast %b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                    mismatch_count++;
                end else begin
                    want = records_due.pop_front();
                    mismatch_count += field_err("record_type", want.rec_type, i_m_tuser);
                    mismatch_count += field_err("byte_offset", want.ofs, i_m_tdata[OFS_W-1:0]);
                    mismatch_count += field_err("sp_kind", want.iv.sp_kind, i_m_tdata[SPK_LSB]);
                    mismatch_count += field_err("frame_size", want.iv.frame_size,
                                                $signed(i_m_tdata[FS_LSB +: FS_W]));
                    mismatch_count += field_err("ra_kind", want.iv.ra_kind,
                                                i_m_tdata[RAK_LSB +: RAK_W]);
                    mismatch_count += field_err("ra_offset", want.iv.ra_offset,
                                                $signed(i_m_tdata[RAO_LSB +: RAO_W]));
                    mismatch_count += field_err("last_of_run", want.run_end, i_m_tlast);
                end
            end
        end
        o_mismatch_count <= mismatch_count;
        o_records_due    <= records_due.size();
    end

endmodule

`default_nettype wire

FILE: tb/prologue_epilogue_frame_tracker_test.sv
// ----------------------------------------------------------------------------
// prologue_epilogue_frame_tracker_test
// Feeds the frame tracker hand-written function bodies that cover each
// rule and corner, one body padded with filler words, and random
// well-formed and broken prologue/epilogue sequences, with random idling
// on both stream sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module prologue_epilogue_frame_tracker_test;
    import pft_pkg::*;

    localparam int MAX_W      = 65536;
    localparam int PTR_B      = 8;
    localparam int HOLD_TICKS = 300;

    // extended opcodes of the X-form words the tracker decodes
    localparam logic [9:0] XO_STWUX = 10'd183;
    localparam logic [9:0] XO_OR    = 10'd444;
    localparam logic [31:0] INSN_NOP = 32'h60000000;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_valid  = 1'b0;
    logic [31:0]        s_data   = '0;
    logic               s_last   = 1'b0;
    logic               m_ready  = 1'b0;
    wire logic          s_ready;
    wire logic          m_valid;
    wire logic [TDATA_W-1:0] m_data;
    wire logic          m_user;
    wire logic          m_last;
    int                 mismatches;
    int                 records_due;

    bit                 tx_idle  = 1'b1;
    bit                 rx_idle  = 1'b1;
    bit                 hold_req = 1'b0;
    int                 words_sent = 0;
    int                 rand_base;

    prologue_epilogue_frame_tracker #(
        .MAX_WORDS     (MAX_W),
        .POINTER_BYTES (PTR_B)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    pft_checker #(
        .MAX_WORDS     (MAX_W),
        .POINTER_BYTES (PTR_B)
    ) record_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_valid),
        .i_s_tready       (s_ready),
        .i_s_tdata        (s_data),
        .i_s_tlast        (s_last),
        .i_m_tvalid       (m_valid),
        .i_m_tready       (m_ready),
        .i_m_tdata        (m_data),
        .i_m_tuser        (m_user),
        .i_m_tlast        (m_last),
        .o_mismatch_count (mismatches),
        .o_records_due    (records_due)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [31:0] x_form(logic [4:0] rs, logic [4:0] rb, logic [9:0] xo);
        return {6'd31, rs, 5'd1, rb, xo, 1'b0};
    endfunction

    // Offer one word and hold it until the transaction completes.
    task automatic send_word(input logic [31:0] w, input logic fin);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        s_last  <= fin;
        do @(posedge clk); while (!s_ready);
        words_sent++;
    endtask

    // Random function body: prologue, mixed body, epilogue. Each prologue
    // and epilogue step is sometimes dropped to get broken sequences.
    task automatic emit_function();
        int          fsz;
        logic        stack_x;
        logic [15:0] ra_disp;
        logic [4:0]  rx;
        logic [31:0] fn[$];
        fsz     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32768)
                                              : 8 * $urandom_range(2, 64);
        stack_x = ($urandom_range(0, 4) == 0);
        ra_disp = stack_x ? 16'(PTR_B - 1) : 16'(fsz + PTR_B);

        if ($urandom_range(0, 7) != 0) fn.push_back(INSN_MFLR);
        if ($urandom_range(0, 7) != 0)
            fn.push_back(stack_x ? x_form(5'($urandom), 5'($urandom), XO_STWUX)
                                 : {OP_STWU_R1, 16'(-fsz)});
        if ($urandom_range(0, 7) != 0) fn.push_back({OP_STW_R0, ra_disp});
        repeat ($urandom_range(0, 8)) begin
            rx = 5'($urandom);
            case ($urandom_range(0, 11))
                4:  fn.push_back(INSN_MFLR);
                5:  fn.push_back(INSN_MTLR);
                6:  fn.push_back({OP_LWZ_R0, ra_disp});
                7:  fn.push_back({OP_STW_R0, ($urandom_range(0, 1) ? ra_disp : 16'($urandom))});
                8:  fn.push_back(INSN_BLR);
                9:  fn.push_back(x_form(rx, ($urandom_range(0, 3) == 0) ? 5'($urandom) : rx,
                                        XO_OR));
                10: fn.push_back({OP_STWU_R1, 16'($urandom)});
                11: fn.push_back({OP_ADDI_R1, 16'(fsz)});
                default: fn.push_back($urandom);
            endcase
        end
        if ($urandom_range(0, 7) != 0) fn.push_back({OP_LWZ_R0, ra_disp});
        if ($urandom_range(0, 7) != 0) fn.push_back(INSN_MTLR);
        if ($urandom_range(0, 7) != 0) begin
            if (stack_x)
                fn.push_back({OP_ADDI_R1, 16'hFFFF});
            else if ($urandom_range(0, 1) == 0)
                fn.push_back({OP_ADDI_R1, 16'(fsz)});
            else
                fn.push_back(x_form(5'd11, 5'd11, XO_OR));
        end
        fn.push_back(INSN_BLR);
        foreach (fn[i])
            send_word(fn[i], i == fn.size() - 1);
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_TICKS) @(posedge clk);
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(posedge clk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full prologue, saves, restores, interior blr back to canonical
        send_word(INSN_MFLR, 1'b0);
        send_word({OP_STWU_R1, 16'hFFC0}, 1'b0);
        send_word({OP_STW_R0, 16'h0048}, 1'b0);
        send_word({OP_LWZ_R0, 16'h0048}, 1'b0);
        send_word(INSN_MTLR, 1'b0);
        send_word({OP_ADDI_R1, 16'h0040}, 1'b0);
        send_word(INSN_BLR, 1'b0);
        send_word(INSN_BLR, 1'b1);

        // frame of unknown size from stwux
        send_word(x_form(5'd31, 5'd12, XO_STWUX), 1'b0);
        send_word({OP_STW_R0, 16'h0007}, 1'b0);
        send_word(x_form(5'd31, 5'd31, XO_OR), 1'b0);
        send_word({OP_ADDI_R1, 16'hFFFF}, 1'b0);
        send_word({OP_LWZ_R0, 16'h0008}, 1'b1);

        // extreme frame sizes, mr with positive and negative frames
        send_word({OP_STWU_R1, 16'h8000}, 1'b0);
        send_word(x_form(5'd0, 5'd0, XO_OR), 1'b0);
        send_word({OP_STWU_R1, 16'h7FFF}, 1'b0);
        send_word({OP_STW_R0, 16'h8009}, 1'b0);
        send_word(x_form(5'd5, 5'd5, XO_OR), 1'b0);
        send_word({OP_STW_R0, 16'h0010}, 1'b0);
        send_word(INSN_BLR, 1'b1);

        // one-word functions
        send_word(INSN_MFLR, 1'b1);
        send_word(32'hFFFFFFFF, 1'b1);

        // filler words between the rule words, sent back to back
        tx_idle = 1'b0;
        send_word(32'h00000000, 1'b0);
        repeat (20) send_word(INSN_NOP, 1'b0);
        send_word(INSN_MFLR, 1'b0);
        send_word(INSN_MTLR, 1'b1);

        rand_base = words_sent;
        hold_req  = 1'b1;
        while (words_sent - rand_base < 250) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0)
                emit_function();
            else
                repeat ($urandom_range(1, 4))
                    send_word($urandom, $urandom_range(0, 7) == 0);
        end
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        while (words_sent - rand_base < 300)
            emit_function();
        s_valid <= 1'b0;

        @(posedge clk);
        while (records_due != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
